// ===== rtl/tp4_pkg.sv =====
// Package for the 4-D tensor permute address generator.
// Holds widths, register indexes, shared types and the dimension clamp function.
// No dependencies.
package tp4_pkg;

   localparam int DEFAULT_DIM_BITS = 8;
   localparam int NUM_AXES         = 4;
   localparam int DIM_REG_W        = 9;
   localparam int AXIS_W           = 2;
   localparam int ADDR_W           = 32;
   localparam int ELEM_W           = 32;
   localparam int EFF_W            = 17;
   localparam int CSR_INDEX_W      = 4;
   localparam int CSR_DATA_W       = 9;
   localparam int QDEPTH           = 2;
   localparam int QPTR_W           = $clog2(QDEPTH);
   localparam int QCNT_W           = $clog2(QDEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_DIM_A     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_B     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_C     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_D     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_OUT0 = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_OUT1 = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_OUT2 = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_OUT3 = 4'd7;

   typedef enum logic [1:0] {
      STR_IDLE,
      STR_PROD,
      STR_SCATTER
   } str_state_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][ADDR_W-1:0]    strides;
      logic [NUM_AXES-1:0][DIM_REG_W-1:0] dims;
      logic                               bad;
      logic                               busy;
      logic                               restart;
   } cfg_type;

   typedef struct packed {
      logic [ELEM_W-1:0] elem;
      logic [ADDR_W-1:0] sum_hi;
      logic [ADDR_W-1:0] sum_lo;
      logic              last;
      logic              bad;
   } qent_type;

   // Effective size of an axis: zero acts as one, and the size is capped at 2^dim_bits.
   function automatic logic [EFF_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] r,
                                                input int unsigned dim_bits);
      logic [EFF_W:0] lim;
      lim = (EFF_W + 1)'(1) << dim_bits;
      if (r == '0) begin
         return EFF_W'(1);
      end else if ((EFF_W + 1)'(r) > lim) begin
         return lim[EFF_W-1:0];
      end else begin
         return EFF_W'(r);
      end
   endfunction

endpackage

// ===== rtl/tp4_stride.sv =====
// Configuration registers and stride sequencer of the permute address generator.
// Recomputes the per-axis output strides (product, then scatter) after each write.
// Depends on tp4_pkg.
module tp4_stride #(
   parameter int DIM_BITS = tp4_pkg::DEFAULT_DIM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tp4_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tp4_pkg::CSR_DATA_W-1:0]     csr_data,
   output tp4_pkg::cfg_type                   cfg
);

   localparam int NA = tp4_pkg::NUM_AXES;
   localparam int AW = tp4_pkg::ADDR_W;

   logic [NA-1:0][tp4_pkg::DIM_REG_W-1:0] dim_ff, dim_in;
   logic [NA-1:0][tp4_pkg::AXIS_W-1:0]    axis_ff, axis_in;
   logic [NA-1:0][tp4_pkg::AXIS_W-1:0]    perm_ff, perm_in;
   logic [NA-1:0][AW-1:0]                 strides_ff, strides_in;
   logic                                  bad_ff, bad_in;
   logic [AW-1:0]                         ostr2_ff, ostr2_in;
   logic [AW-1:0]                         ostr1_ff, ostr1_in;
   logic [tp4_pkg::EFF_W-1:0]             e1_ff, e1_in;
   tp4_pkg::str_state_type                state_ff, state_in;

   logic                                  write_acc;
   logic [NA-1:0]                         seen;
   logic                                  bad_now;
   logic [NA-1:0][tp4_pkg::AXIS_W-1:0]    perm_now;
   logic [tp4_pkg::EFF_W-1:0]             e2, e3;
   logic [2*tp4_pkg::EFF_W-1:0]           prod12;
   logic [AW+tp4_pkg::EFF_W-1:0]          prod0;
   logic [NA-1:0][AW-1:0]                 ostr;

   assign csr_ready = 1'b1;
   assign write_acc = csr_valid && (csr_index <= tp4_pkg::REG_AXIS_OUT3);

   always_comb begin
      dim_in  = dim_ff;
      axis_in = axis_ff;
      if (write_acc) begin
         case (csr_index)
            tp4_pkg::REG_DIM_A:     dim_in[0]  = csr_data;
            tp4_pkg::REG_DIM_B:     dim_in[1]  = csr_data;
            tp4_pkg::REG_DIM_C:     dim_in[2]  = csr_data;
            tp4_pkg::REG_DIM_D:     dim_in[3]  = csr_data;
            tp4_pkg::REG_AXIS_OUT0: axis_in[0] = csr_data[tp4_pkg::AXIS_W-1:0];
            tp4_pkg::REG_AXIS_OUT1: axis_in[1] = csr_data[tp4_pkg::AXIS_W-1:0];
            tp4_pkg::REG_AXIS_OUT2: axis_in[2] = csr_data[tp4_pkg::AXIS_W-1:0];
            tp4_pkg::REG_AXIS_OUT3: axis_in[3] = csr_data[tp4_pkg::AXIS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      seen = '0;
      for (int k = 0; k < NA; k++) begin
         seen[axis_ff[k]] = 1'b1;
      end
      bad_now = (seen != '1);
      for (int k = 0; k < NA; k++) begin
         perm_now[k] = bad_now ? tp4_pkg::AXIS_W'(k) : axis_ff[k];
      end
      e3     = tp4_pkg::eff_dim(dim_ff[perm_now[3]], DIM_BITS);
      e2     = tp4_pkg::eff_dim(dim_ff[perm_now[2]], DIM_BITS);
      prod12 = e3 * e2;
      prod0  = ostr1_ff * e1_ff;
      ostr[3] = AW'(1);
      ostr[2] = ostr2_ff;
      ostr[1] = ostr1_ff;
      ostr[0] = prod0[AW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tp4_pkg::STR_IDLE:    state_in = tp4_pkg::STR_IDLE;
         tp4_pkg::STR_PROD:    state_in = tp4_pkg::STR_SCATTER;
         tp4_pkg::STR_SCATTER: state_in = tp4_pkg::STR_IDLE;
         default:              state_in = tp4_pkg::STR_IDLE;
      endcase
      if (write_acc) begin
         state_in = tp4_pkg::STR_PROD;
      end
   end

   always_comb begin
      perm_in    = perm_ff;
      bad_in     = bad_ff;
      ostr2_in   = ostr2_ff;
      ostr1_in   = ostr1_ff;
      e1_in      = e1_ff;
      strides_in = strides_ff;
      case (state_ff)
         tp4_pkg::STR_PROD: begin
            perm_in  = perm_now;
            bad_in   = bad_now;
            ostr2_in = AW'(e3);
            ostr1_in = AW'(prod12);
            e1_in    = tp4_pkg::eff_dim(dim_ff[perm_now[1]], DIM_BITS);
         end
         tp4_pkg::STR_SCATTER: begin
            for (int k = 0; k < NA; k++) begin
               strides_in[perm_ff[k]] = ostr[k];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tp4_pkg::STR_IDLE;
         bad_ff   <= 1'b0;
         for (int k = 0; k < NA; k++) begin
            dim_ff[k]     <= tp4_pkg::DIM_REG_W'(1);
            axis_ff[k]    <= tp4_pkg::AXIS_W'(k);
            perm_ff[k]    <= tp4_pkg::AXIS_W'(k);
            strides_ff[k] <= AW'(1);
         end
      end else begin
         state_ff   <= state_in;
         bad_ff     <= bad_in;
         dim_ff     <= dim_in;
         axis_ff    <= axis_in;
         perm_ff    <= perm_in;
         strides_ff <= strides_in;
      end
   end

   always_ff @(posedge clock) begin
      ostr2_ff <= ostr2_in;
      ostr1_ff <= ostr1_in;
      e1_ff    <= e1_in;
   end

   always_comb begin
      cfg.strides = strides_ff;
      cfg.dims    = dim_ff;
      cfg.bad     = bad_ff;
      cfg.busy    = (state_ff != tp4_pkg::STR_IDLE) || csr_valid;
      cfg.restart = write_acc;
   end

endmodule

// ===== rtl/tp4_front.sv =====
// Front end of the permute address generator: takes input transfers, steps the
// mixed-radix position counter and its per-axis address terms. Depends on tp4_pkg.
module tp4_front #(
   parameter int DIM_BITS = tp4_pkg::DEFAULT_DIM_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tp4_pkg::ELEM_W-1:0]    req_tdata,
   input  tp4_pkg::cfg_type              cfg,
   input  logic                          q_full,
   output logic                          q_push,
   output tp4_pkg::qent_type             q_data
);

   localparam int NA = tp4_pkg::NUM_AXES;
   localparam int AW = tp4_pkg::ADDR_W;

   logic [NA-1:0][DIM_BITS-1:0] digit_ff, digit_in;
   logic [NA-1:0][AW-1:0]       part_ff, part_in;
   logic [NA-1:0][DIM_BITS-1:0] max_digit;
   logic [NA-1:0]               at_max;
   logic [tp4_pkg::EFF_W-1:0]   eff;
   logic                        carry;

   assign req_tready = !cfg.busy && !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < NA; k++) begin
         eff          = tp4_pkg::eff_dim(cfg.dims[k], DIM_BITS) - tp4_pkg::EFF_W'(1);
         max_digit[k] = eff[DIM_BITS-1:0];
         at_max[k]    = (digit_ff[k] == max_digit[k]);
      end
   end

   always_comb begin
      q_data.elem   = req_tdata;
      q_data.sum_hi = part_ff[0] + part_ff[1];
      q_data.sum_lo = part_ff[2] + part_ff[3];
      q_data.last   = &at_max;
      q_data.bad    = cfg.bad;
   end

   always_comb begin
      digit_in = digit_ff;
      part_in  = part_ff;
      carry    = 1'b1;
      if (cfg.restart) begin
         digit_in = '0;
         part_in  = '0;
      end else if (q_push) begin
         for (int k = NA - 1; k >= 0; k--) begin
            if (carry) begin
               if (at_max[k]) begin
                  digit_in[k] = '0;
                  part_in[k]  = '0;
               end else begin
                  digit_in[k] = digit_ff[k] + DIM_BITS'(1);
                  part_in[k]  = part_ff[k] + cfg.strides[k];
                  carry       = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         part_ff  <= '0;
      end else begin
         digit_ff <= digit_in;
         part_ff  <= part_in;
      end
   end

endmodule

// ===== rtl/tp4_queue.sv =====
// Short queue between the front end and the back end of the permute address
// generator, held in a small register memory. Depends on tp4_pkg.
module tp4_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tp4_pkg::qent_type  push_data,
   input  logic               pop,
   output tp4_pkg::qent_type  pop_data,
   output logic               full,
   output logic               empty
);

   tp4_pkg::qent_type               mem_ff [tp4_pkg::QDEPTH];
   logic [tp4_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tp4_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tp4_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full     = (count_ff == tp4_pkg::QCNT_W'(tp4_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tp4_pkg::QPTR_W'(tp4_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + tp4_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tp4_pkg::QPTR_W'(tp4_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + tp4_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + tp4_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tp4_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tp4_back.sv =====
// Back end of the permute address generator: completes the output address and
// holds the result in the output register until it is taken. Depends on tp4_pkg.
module tp4_back (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_empty,
   input  tp4_pkg::qent_type                             q_data,
   output logic                                          q_pop,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [tp4_pkg::ADDR_W+tp4_pkg::ELEM_W-1:0]    rsp_tdata,
   output logic                                          rsp_tlast,
   output logic                                          rsp_tuser
);

   logic                          valid_ff, valid_in;
   logic [tp4_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [tp4_pkg::ELEM_W-1:0]    elem_ff, elem_in;
   logic                          last_ff, last_in;
   logic                          bad_ff, bad_in;

   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      elem_in  = elem_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         addr_in  = q_data.sum_hi + q_data.sum_lo;
         elem_in  = q_data.elem;
         last_in  = q_data.last;
         bad_in   = q_data.bad;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      elem_ff <= elem_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {elem_ff, addr_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = bad_ff;

endmodule

// ===== rtl/tensor_permute_4d_address_gen.sv =====
// An accepted input is queued, then its result is offered from the output register.
// Throughput: one element per cycle unless the queue is full, set by the single-step
// position counter and one pair of address adds per element in the front end.
// After a register write no input is taken in the write cycle or while the stride
// sequencer forms its two products. Synchronous active-high reset restores identity
// permutation, unit dimensions and a cleared position counter.
module tensor_permute_4d_address_gen #(
   parameter int DIM_BITS = tp4_pkg::DEFAULT_DIM_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // elem_bits [31:0]
   input  logic [tp4_pkg::ELEM_W-1:0]                    req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // dest_address [31:0], elem_out [63:32]
   output logic [tp4_pkg::ADDR_W+tp4_pkg::ELEM_W-1:0]    rsp_tdata,
   output logic                                          rsp_tlast,
   // bad_permutation [0]
   output logic                                          rsp_tuser,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [tp4_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  logic [tp4_pkg::CSR_DATA_W-1:0]                csr_data
);

   tp4_pkg::cfg_type  cfg;
   tp4_pkg::qent_type push_data;
   tp4_pkg::qent_type pop_data;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;

   tp4_stride #(
      .DIM_BITS (DIM_BITS)
   ) u_stride (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tp4_front #(
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .q_full     (q_full),
      .q_push     (push),
      .q_data     (push_data)
   );

   tp4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   tp4_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (pop_data),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
